/* rtl/rc4_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  typedef logic [7:0] byte_t;

  // Request codes on in_operation
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_CRYPT = 2'd2;

  // Last entry of the permutation sweep
  localparam byte_t STEP_LAST = 8'hFF;

  // Width of the key length register
  localparam int unsigned KLEN_W = 9;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FILL = 9'b000000010,
    ST_KRS  = 9'b000000100,
    ST_KRJ  = 9'b000001000,
    ST_KWS  = 9'b000010000,
    ST_KWJ  = 9'b000100000,
    ST_ERJ  = 9'b001000000,
    ST_ESW  = 9'b010000000,
    ST_EWJ  = 9'b100000000
  } state_t;

  // Access to the permutation memory
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } perm_req_t;

endpackage

`default_nettype wire

/* rtl/rc4_perm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc4_perm_ram
  import rc4_pkg::*;
(
  input  wire logic      clk,
  input  wire perm_req_t req,
  output byte_t          rd_data
);

  byte_t mem [256];
  byte_t rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/rc4_key_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc4_key_ram
  import rc4_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire byte_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output byte_t              rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // Store key bytes, read the current key position
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/rc4_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 256,
  parameter int unsigned KW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_operation,
  input  wire byte_t             in_key_index,
  input  wire byte_t             in_key_byte,
  input  wire byte_t             in_data_byte,
  input  wire logic              cfg_we,
  input  wire logic [KLEN_W-1:0] cfg_key_length,
  output logic                   out_valid,
  output byte_t                  out_data_out,
  output perm_req_t              perm_req,
  input  wire byte_t             perm_rdata,
  output logic                   key_we,
  output logic [KW-1:0]          key_waddr,
  output byte_t                  key_wdata,
  output logic [KW-1:0]          key_raddr,
  input  wire byte_t             key_rdata
);

  state_t              state_r, state_nxt;
  byte_t               cnt_r, cnt_nxt;
  logic [KW-1:0]       pos_r, pos_nxt;
  byte_t               i_r, i_nxt;
  byte_t               j_r, j_nxt;
  byte_t               si_r, si_nxt;
  byte_t               sj_r, sj_nxt;
  logic                fi_r, fi_nxt;
  logic                fj_r, fj_nxt;
  byte_t               data_r, data_nxt;
  logic                ov_r, ov_nxt;
  byte_t               od_r, od_nxt;
  logic [KLEN_W-1:0]   klen_r;
  logic [KLEN_W-1:0]   len_m1;
  logic                pos_last;
  logic                key_in_range;
  byte_t               sum_ksa;
  byte_t               sum_j;
  byte_t               sum_t;
  byte_t               ks;

  // Last key position in use: zero acts as one, oversize clamps to depth
  assign len_m1 = (klen_r == '0) ? '0 :
                  (klen_r > KLEN_W'(KEY_DEPTH)) ? KLEN_W'(KEY_DEPTH - 1) :
                  klen_r - KLEN_W'(1);
  assign pos_last     = (KLEN_W'(pos_r) == len_m1);
  assign key_in_range = ({1'b0, in_key_index} < KLEN_W'(KEY_DEPTH));

  assign sum_ksa = j_r + perm_rdata + key_rdata;
  assign sum_j   = j_r + perm_rdata;
  assign sum_t   = si_r + perm_rdata;
  assign ks      = fi_r ? sj_r : (fj_r ? si_r : perm_rdata);

  assign key_waddr = in_key_index[KW-1:0];
  assign key_wdata = in_key_byte;
  assign key_raddr = pos_r;

  // Sequence key byte writes, key schedule and keystream steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    fi_nxt    = fi_r;
    fj_nxt    = fj_r;
    data_nxt  = data_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    key_we    = 1'b0;
    perm_req.we    = 1'b0;
    perm_req.waddr = i_r;
    perm_req.wdata = si_r;
    perm_req.raddr = i_r + 8'd1;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_KEY: begin
              key_we = key_in_range;
            end
            OP_SCHED: begin
              state_nxt = ST_FILL;
              cnt_nxt   = '0;
              pos_nxt   = '0;
              i_nxt     = '0;
              j_nxt     = '0;
            end
            OP_CRYPT: begin
              state_nxt = ST_ERJ;
              data_nxt  = in_data_byte;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = cnt_r;
        perm_req.wdata = cnt_r;
        cnt_nxt        = cnt_r + 8'd1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = ST_KRS;
        end
      end
      ST_KRS: begin
        perm_req.raddr = cnt_r;
        state_nxt      = ST_KRJ;
      end
      ST_KRJ: begin
        j_nxt          = sum_ksa;
        si_nxt         = perm_rdata;
        perm_req.raddr = sum_ksa;
        state_nxt      = ST_KWS;
      end
      ST_KWS: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = cnt_r;
        perm_req.wdata = perm_rdata;
        state_nxt      = ST_KWJ;
      end
      ST_KWJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = si_r;
        cnt_nxt        = cnt_r + 8'd1;
        pos_nxt        = pos_last ? '0 : pos_r + KW'(1);
        if (cnt_r == STEP_LAST) begin
          state_nxt = ST_IDLE;
          i_nxt     = '0;
          j_nxt     = '0;
        end else begin
          state_nxt = ST_KRS;
        end
      end
      ST_ERJ: begin
        i_nxt          = i_r + 8'd1;
        si_nxt         = perm_rdata;
        j_nxt          = sum_j;
        perm_req.raddr = sum_j;
        state_nxt      = ST_ESW;
      end
      ST_ESW: begin
        // Write S[i], read the output entry; flag hits on the swapped pair
        perm_req.we    = 1'b1;
        perm_req.waddr = i_r;
        perm_req.wdata = perm_rdata;
        perm_req.raddr = sum_t;
        sj_nxt         = perm_rdata;
        fi_nxt         = (sum_t == i_r);
        fj_nxt         = (sum_t == j_r);
        state_nxt      = ST_EWJ;
      end
      ST_EWJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = si_r;
        ov_nxt         = 1'b1;
        od_nxt         = data_r ^ ks;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      ov_r    <= 1'b0;
      klen_r  <= KLEN_W'(1);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        klen_r <= cfg_key_length;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    fi_r   <= fi_nxt;
    fj_r   <= fj_nxt;
    data_r <= data_nxt;
    od_r   <= od_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = ov_r;
  assign out_data_out = od_r;

endmodule

`default_nettype wire

/* rtl/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none

// RC4 cipher engine with a command interface.
// A request is taken at a clock edge with start high and busy low; in_operation
// selects a key byte write, a key schedule or a data byte encrypt.
// Key byte write: stored at once into the key store, busy stays low.
// Key schedule: fills the 256-entry permutation, then runs 256 swap steps,
//   each two reads and two writes on the single-port-write permutation memory;
//   busy is high throughout. Both stream indices are cleared.
// Encrypt: busy while it reads S[j], writes S[i] with a read of the output
//   entry, then writes S[j]; a new request is taken only after the last
//   write, so encrypts never overlap. The dependent read chain through the
//   permutation memory serialises them. out_valid is registered from the last
//   step and strobes out_data_out for one cycle; the receiver cannot stall
//   and must take it then.
// Configuration: cfg_we writes cfg_key_length (key bytes in use); assert it
// only while idle, unenforced by the block. Reset (rst_n low, synchronous)
// returns to idle, clears both indices and sets the key length to 1. Memories
// are not cleared: load key bytes and run a schedule before encrypting.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_operation,
  input  wire byte_t             in_key_index,
  input  wire byte_t             in_key_byte,
  input  wire byte_t             in_data_byte,
  input  wire logic              cfg_we,
  input  wire logic [KLEN_W-1:0] cfg_key_length,
  output logic                   out_valid,
  output byte_t                  out_data_out
);

  localparam int unsigned KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  perm_req_t     perm_req;
  byte_t         perm_rdata;
  logic          key_we;
  logic [KW-1:0] key_waddr;
  byte_t         key_wdata;
  logic [KW-1:0] key_raddr;
  byte_t         key_rdata;

  rc4_ctrl #(
    .KEY_DEPTH (KEY_DEPTH),
    .KW        (KW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key_index   (in_key_index),
    .in_key_byte    (in_key_byte),
    .in_data_byte   (in_data_byte),
    .cfg_we         (cfg_we),
    .cfg_key_length (cfg_key_length),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .perm_req       (perm_req),
    .perm_rdata     (perm_rdata),
    .key_we         (key_we),
    .key_waddr      (key_waddr),
    .key_wdata      (key_wdata),
    .key_raddr      (key_raddr),
    .key_rdata      (key_rdata)
  );

  rc4_perm_ram u_perm_ram (
    .clk     (clk),
    .req     (perm_req),
    .rd_data (perm_rdata)
  );

  rc4_key_ram #(
    .DEPTH (KEY_DEPTH),
    .AW    (KW)
  ) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .waddr   (key_waddr),
    .wdata   (key_wdata),
    .raddr   (key_raddr),
    .rd_data (key_rdata)
  );

endmodule

`default_nettype wire

/* verif/rc4_stream_cipher_tb.sv */
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  // Code left unused by the block; a request carrying it is dropped
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned N_TARGET = 1600;
  localparam int unsigned MAX_SHOWN = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_operation;
  byte_t               in_key_index;
  byte_t               in_key_byte;
  byte_t               in_data_byte;
  logic                cfg_we;
  logic [KLEN_W-1:0]   cfg_key_length;
  logic                out_valid;
  byte_t               out_data_out;

  // Shadow copy of the cipher state
  byte_t               perm_shadow [256];
  byte_t               key_shadow [256];
  bit                  key_loaded [256];
  byte_t               idx_i;
  byte_t               idx_j;
  logic [KLEN_W-1:0]   klen_shadow;

  // Output bytes still owed by the block, oldest first
  byte_t               pending_bytes [$];

  int unsigned         mismatches;
  int unsigned         n_items;
  int unsigned         n_keys;
  int unsigned         n_scheds;
  int unsigned         n_crypts;
  int unsigned         n_spare;
  int unsigned         n_cfg;
  int unsigned         n_checked;

  typedef struct {
    bit                is_cfg;
    logic [KLEN_W-1:0] klen;
    logic [1:0]        op;
    byte_t             key_index;
    byte_t             key_byte;
    byte_t             data_byte;
    bit                has_known;
    byte_t             known_out;
  } stim_row_t;

  stim_row_t           directed_rows [$];

  rc4_stream_cipher DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key_index   (in_key_index),
    .in_key_byte    (in_key_byte),
    .in_data_byte   (in_data_byte),
    .cfg_we         (cfg_we),
    .cfg_key_length (cfg_key_length),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned eff_len(input logic [KLEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // True once every key position in use has been written
  function automatic bit keys_ready();
    int unsigned n;
    n = eff_len(klen_shadow);
    for (int unsigned k = 0; k < n; k++) begin
      if (!key_loaded[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic byte_t rand8();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Key scheduling over the shadow permutation
  task automatic shadow_schedule();
    int unsigned n;
    int unsigned pos;
    byte_t jj;
    byte_t t;
    n = eff_len(klen_shadow);
    for (int s = 0; s < 256; s++) perm_shadow[s] = byte_t'(s);
    jj = 8'd0;
    pos = 0;
    for (int s = 0; s < 256; s++) begin
      jj = jj + perm_shadow[s] + key_shadow[pos];
      t = perm_shadow[s];
      perm_shadow[s] = perm_shadow[jj];
      perm_shadow[jj] = t;
      pos++;
      if (pos >= n) pos = 0;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
  endtask

  // One keystream step, returns the data byte XORed with the keystream byte
  function automatic byte_t shadow_crypt(input byte_t d);
    byte_t t;
    byte_t sel;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_shadow[idx_i];
    t = perm_shadow[idx_i];
    perm_shadow[idx_i] = perm_shadow[idx_j];
    perm_shadow[idx_j] = t;
    sel = perm_shadow[idx_i] + perm_shadow[idx_j];
    return d ^ perm_shadow[sel];
  endfunction

  // Present one request, hold it until taken, then update the shadow state
  task automatic issue(input logic [1:0] op, input byte_t ki, input byte_t kb,
                       input byte_t db);
    start        <= 1'b1;
    in_operation <= op;
    in_key_index <= ki;
    in_key_byte  <= kb;
    in_data_byte <= db;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_KEY: begin
        key_shadow[ki] = kb;
        key_loaded[ki] = 1'b1;
        n_keys++;
        n_items++;
      end
      OP_SCHED: begin
        shadow_schedule();
        n_scheds++;
        n_items++;
      end
      OP_CRYPT: begin
        pending_bytes.push_back(shadow_crypt(db));
        n_crypts++;
        n_items++;
      end
      default: n_spare++;
    endcase
  endtask

  // Drop start for a while
  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pause(input bit calm);
    idle_for(calm ? 0 : gap_len());
  endtask

  // Drain all results, let any schedule finish, then write the key length
  task automatic set_key_length(input logic [KLEN_W-1:0] v);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_key_length <= v;
    @(posedge clk);
    cfg_we         <= 1'b0;
    cfg_key_length <= KLEN_W'($urandom_range(0, 511));
    klen_shadow = v;
    n_cfg++;
  endtask

  // Odd request slipped into a sequence; a schedule only once the key is loaded
  task automatic noise_request(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4)
      issue(OP_SPARE, rand8(), rand8(), rand8());
    else if (r < 8)
      issue(OP_KEY, rand8(), rand8(), rand8());
    else if (r < 9)
      issue(OP_CRYPT, rand8(), rand8(), rand8());
    else if (keys_ready())
      issue(OP_SCHED, rand8(), rand8(), rand8());
    else
      issue(OP_SPARE, rand8(), rand8(), rand8());
    pause(calm);
  endtask

  // Load a key of the given length, schedule, then stream data bytes
  task automatic run_phase(input logic [KLEN_W-1:0] klen_val);
    int unsigned n;
    int unsigned n_data;
    bit calm;
    set_key_length(klen_val);
    calm = ($urandom_range(0, 3) == 0);
    n = eff_len(klen_val);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) noise_request(calm);
      issue(OP_KEY, byte_t'(k), rand8(), rand8());
      pause(calm);
    end
    issue(OP_SCHED, rand8(), rand8(), rand8());
    pause(calm);
    n_data = $urandom_range(20, 90);
    for (int k = 0; k < n_data; k++) begin
      if ($urandom_range(0, 9) == 0) noise_request(calm);
      issue(OP_CRYPT, rand8(), rand8(), rand8());
      pause(calm);
    end
  endtask

  function automatic stim_row_t row_req(input logic [1:0] op, input byte_t ki,
                                        input byte_t kb, input byte_t db);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.key_index = ki;
    r.key_byte = kb;
    r.data_byte = db;
    return r;
  endfunction

  function automatic stim_row_t row_known(input byte_t db, input byte_t res);
    stim_row_t r;
    r = row_req(OP_CRYPT, 8'h00, 8'h00, db);
    r.has_known = 1'b1;
    r.known_out = res;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [KLEN_W-1:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.klen = v;
    return r;
  endfunction

  // Check each strobed byte against the oldest pending one
  always @(posedge clk) begin
    byte_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: data_out %02h", out_data_out);
      end else begin
        want = pending_bytes.pop_front();
        n_checked++;
        if (out_data_out !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: data_out expected %02h got %02h", want, out_data_out);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int unsigned phase;
    logic [KLEN_W-1:0] klen_pick;
    int unsigned r;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_KEY;
    in_key_index   = 8'h00;
    in_key_byte    = 8'h00;
    in_data_byte   = 8'h00;
    cfg_we         = 1'b0;
    cfg_key_length = '0;
    klen_shadow    = 1;
    idx_i          = 8'd0;
    idx_j          = 8'd0;
    mismatches     = 0;
    n_items        = 0;
    n_keys         = 0;
    n_scheds       = 0;
    n_crypts       = 0;
    n_spare        = 0;
    n_cfg          = 0;
    n_checked      = 0;
    for (int k = 0; k < 256; k++) begin
      perm_shadow[k] = 8'h00;
      key_shadow[k]  = 8'h00;
      key_loaded[k]  = 1'b0;
    end

    // Known vector: key "Key", plaintext "Plaintext"
    directed_rows.push_back(row_cfg(3));
    directed_rows.push_back(row_req(OP_KEY, 8'd0, 8'h4B, 8'h00));
    directed_rows.push_back(row_req(OP_KEY, 8'd1, 8'h65, 8'hFF));
    directed_rows.push_back(row_req(OP_KEY, 8'd2, 8'h79, 8'h00));
    directed_rows.push_back(row_req(OP_SCHED, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(row_known(8'h50, 8'hBB));
    directed_rows.push_back(row_known(8'h6C, 8'hF3));
    directed_rows.push_back(row_known(8'h61, 8'h16));
    directed_rows.push_back(row_known(8'h69, 8'hE8));
    directed_rows.push_back(row_known(8'h6E, 8'hD9));
    directed_rows.push_back(row_known(8'h74, 8'h40));
    directed_rows.push_back(row_known(8'h65, 8'hAF));
    directed_rows.push_back(row_known(8'h78, 8'h0A));
    directed_rows.push_back(row_known(8'h74, 8'hD3));
    // Unused code is dropped and leaves the stream alone
    directed_rows.push_back(row_req(OP_SPARE, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(row_req(OP_CRYPT, 8'hFF, 8'hFF, 8'hFF));
    // Zero length acts as one; extreme key index and bytes
    directed_rows.push_back(row_cfg(0));
    directed_rows.push_back(row_req(OP_KEY, 8'd0, 8'hFF, 8'hFF));
    directed_rows.push_back(row_req(OP_KEY, 8'd255, 8'h00, 8'h00));
    directed_rows.push_back(row_req(OP_SCHED, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_req(OP_CRYPT, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_req(OP_SPARE, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_req(OP_CRYPT, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(row_cfg(1));
    directed_rows.push_back(row_req(OP_SCHED, 8'h5A, 8'hA5, 8'h5A));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_cfg) begin
        set_key_length(row.klen);
      end else begin
        issue(row.op, row.key_index, row.key_byte, row.data_byte);
        if (row.has_known) pending_bytes[pending_bytes.size() - 1] = row.known_out;
        pause(1'b0);
      end
    end

    // Random phases: all-ones, zero and full length first, then mostly short keys
    phase = 0;
    while (n_items < N_TARGET) begin
      if (phase == 0) begin
        klen_pick = 9'd511;
      end else if (phase == 1) begin
        klen_pick = 9'd0;
      end else if (phase == 2) begin
        klen_pick = 9'd256;
      end else begin
        r = $urandom_range(0, 29);
        if (r == 0)      klen_pick = 9'd256;
        else if (r == 1) klen_pick = KLEN_W'($urandom_range(257, 511));
        else if (r == 2) klen_pick = 9'd0;
        else if (r == 3) klen_pick = 9'd1;
        else             klen_pick = KLEN_W'($urandom_range(1, 16));
      end
      run_phase(klen_pick);
      phase++;
    end

    // Drain, then wait for any stray strobe
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d key writes, %0d schedules, %0d encrypts, %0d dropped requests",
             n_keys, n_scheds, n_crypts, n_spare);
    $display("over %0d key length settings, %0d output bytes checked, %0d mismatches",
             n_cfg, n_checked, mismatches);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* rc4_stream_cipher.f */
rtl/rc4_pkg.sv
rtl/rc4_perm_ram.sv
rtl/rc4_key_ram.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher.sv
verif/rc4_stream_cipher_tb.sv
